// ===== rtl/pkw_pkg.sv =====
// Package for the packet keyword matcher.
// Holds command, result and status codes, the default keyword and the
// structs passed between the top level and the keyword cells.
`default_nettype none
package pkw_pkg;

  typedef enum logic [1:0] {
    CMD_PACKET  = 2'd0,
    CMD_KEYWORD = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    XFER_CONTROL   = 2'd0,
    XFER_ISOCH     = 2'd1,
    XFER_BULK      = 2'd2,
    XFER_INTERRUPT = 2'd3
  } xfer_e;

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_TABLE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  // Default keyword "OPEN", first character in the top byte.
  localparam logic [31:0] DEFAULT_KEYWORD = 32'h4F50454E;
  localparam int unsigned DEFAULT_LEN     = 4;

  typedef struct packed {
    logic match_en;
    logic write_en;
    logic clear_hits;
    logic load_default;
  } cell_ctrl_t;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
    logic       dup;
  } hit_chain_t;

endpackage
`default_nettype wire

// ===== rtl/pkw_cell.sv =====
// One keyword cell: holds one right-aligned keyword, its length and hit flag.
// Passes the first-hit and duplicate chain on to its neighbor. Uses pkw_pkg.
`default_nettype none
module pkw_cell #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned LENGTH_LIMIT  = 32,
  parameter int unsigned CELL_INDEX    = 0
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire pkw_pkg::cell_ctrl_t                           ctrl_i,
  input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]            total_i,
  input  wire logic [LENGTH_LIMIT-2:0][7:0]                  window_i,
  input  wire logic [$clog2(LENGTH_LIMIT)-1:0]               fill_i,
  input  wire logic [LENGTH_LIMIT-2:0][7:0]                  stage_i,
  input  wire logic [$clog2(LENGTH_LIMIT)-1:0]               stage_len_i,
  input  wire pkw_pkg::hit_chain_t                           chain_i,
  output pkw_pkg::hit_chain_t                                chain_o
);

  localparam int unsigned WIN = LENGTH_LIMIT - 1;
  localparam int unsigned LW  = $clog2(LENGTH_LIMIT);
  localparam int unsigned TW  = $clog2(TABLE_ENTRIES + 1);

  logic [WIN-1:0][7:0] kw_q, kw_d, kw_default;
  logic [LW-1:0]       len_q, len_d, len_default;
  logic                hit_q, hit_d;
  logic                active, selected, win_eq, stage_eq, hit_now, dup_now, hit_any;

  always_comb begin
    kw_default = '0;
    for (int i = 0; i < 4; i++) begin
      kw_default[WIN-4+i] = pkw_pkg::DEFAULT_KEYWORD[8*(3-i) +: 8];
    end
    len_default = (CELL_INDEX == 0) ? LW'(pkw_pkg::DEFAULT_LEN) : '0;
  end

  assign active   = total_i > TW'(CELL_INDEX);
  assign selected = total_i == TW'(CELL_INDEX);

  // Only the last len_q positions of the window take part in the compare.
  always_comb begin
    win_eq   = 1'b1;
    stage_eq = 1'b1;
    for (int j = 0; j < WIN; j++) begin
      if ((j + int'(len_q)) >= WIN) begin
        if (window_i[j] != kw_q[j]) win_eq = 1'b0;
        if (stage_i[j] != kw_q[j]) stage_eq = 1'b0;
      end
    end
  end

  assign hit_now = ctrl_i.match_en && active && (len_q != '0) && (len_q <= fill_i) && win_eq;
  assign dup_now = active && (len_q == stage_len_i) && stage_eq;
  assign hit_any = active && (hit_q || hit_now);

  always_comb begin
    chain_o.found = chain_i.found || hit_any;
    chain_o.index = chain_i.found ? chain_i.index : 4'(CELL_INDEX);
    chain_o.dup   = chain_i.dup || dup_now;
  end

  always_comb begin
    kw_d  = kw_q;
    len_d = len_q;
    hit_d = hit_q || hit_now;
    if (ctrl_i.clear_hits) begin
      hit_d = 1'b0;
    end
    if (ctrl_i.load_default && (CELL_INDEX == 0)) begin
      kw_d  = kw_default;
      len_d = len_default;
    end
    if (ctrl_i.write_en && selected) begin
      kw_d  = stage_i;
      len_d = stage_len_i;
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q  <= kw_default;
      len_q <= len_default;
      hit_q <= 1'b0;
    end else begin
      kw_q  <= kw_d;
      len_q <= len_d;
      hit_q <= hit_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/packet_keyword_matcher.sv =====
// Top level of the packet keyword matcher: byte window, keyword staging,
// table count, output register and the row of pkw_cell keyword cells.
// Depends on pkw_pkg and pkw_cell.
//
//   Channel  Direction  tdata                      tuser
//   s_axis   in         data_byte                  command, transfer_type
//   m_axis   out        blocked .. table_count     result_kind
//
// A transaction is taken in any cycle in which s_axis_tready is high; a result
// appears in the output register on the next cycle. The cells compare the
// window against all keywords in parallel.
// The input stalls only while a result is held and m_axis_tready is low.
// Reset loads the default keyword table and empties window and staging.
`default_nettype none
module packet_keyword_matcher #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned LENGTH_LIMIT  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [3:0]  s_axis_tuser,   // [1:0] command, [3:2] transfer_type
  input  wire logic        s_axis_tlast,   // last_item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] blocked, [4:1] matched_index,
                                           // [7:5] add_status, [12:8] table_count
  output logic [1:0]       m_axis_tuser    // [1:0] result_kind
);

  localparam int unsigned WIN = LENGTH_LIMIT - 1;
  localparam int unsigned LW  = $clog2(LENGTH_LIMIT);
  localparam int unsigned SW  = $clog2(LENGTH_LIMIT + 1);
  localparam int unsigned TW  = $clog2(TABLE_ENTRIES + 1);

  logic                  accept, searched, is_last, result;
  logic [7:0]            byte_in;
  pkw_pkg::cmd_e         cmd;
  pkw_pkg::cell_ctrl_t   ctrl;
  pkw_pkg::hit_chain_t   chain [TABLE_ENTRIES+1];

  logic [WIN-1:0][7:0]   win_q, win_d, win_n;
  logic [LW-1:0]         fill_q, fill_d, fill_n;
  logic [WIN-1:0][7:0]   stage_q, stage_d;
  logic [SW-1:0]         slen_q, slen_d;
  logic                  ended_q, ended_d;
  logic [TW-1:0]         total_q, total_d;

  logic                  ovalid_q, ovalid_d;
  pkw_pkg::kind_e        okind_q, okind_d;
  logic                  oblk_q, oblk_d;
  logic [3:0]            oidx_q, oidx_d;
  pkw_pkg::status_e      ost_q, ost_d, status;
  logic [4:0]            ocnt_q, ocnt_d;
  logic [31:0]           total_wide;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = pkw_pkg::cmd_e'(s_axis_tuser[1:0]);
  assign byte_in       = s_axis_tdata;
  assign is_last       = s_axis_tlast;
  assign searched      = (s_axis_tuser[3:2] == pkw_pkg::XFER_BULK)
                      || (s_axis_tuser[3:2] == pkw_pkg::XFER_INTERRUPT);

  // Window and staging after this byte, as the cells see them.
  always_comb begin
    win_n = win_q;
    fill_n = fill_q;
    if (searched) begin
      win_n = {byte_in, win_q[WIN-1:1]};
      if (fill_q < LW'(WIN)) fill_n = fill_q + 1'b1;
    end else begin
      fill_n = '0;
    end
    stage_d = stage_q;
    slen_d  = slen_q;
    ended_d = ended_q;
    if (byte_in == 8'd0) begin
      ended_d = 1'b1;
    end else if (!ended_q) begin
      if (slen_q < SW'(WIN)) stage_d = {byte_in, stage_q[WIN-1:1]};
      if (slen_q < SW'(LENGTH_LIMIT)) slen_d = slen_q + 1'b1;
    end
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    pkw_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .LENGTH_LIMIT  (LENGTH_LIMIT),
      .CELL_INDEX    (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .total_i     (total_q),
      .window_i    (win_n),
      .fill_i      (fill_n),
      .stage_i     (stage_d),
      .stage_len_i (slen_d[LW-1:0]),
      .chain_i     (chain[k]),
      .chain_o     (chain[k+1])
    );
  end

  always_comb begin
    if (slen_d == '0) status = pkw_pkg::ST_EMPTY;
    else if (slen_d >= SW'(LENGTH_LIMIT)) status = pkw_pkg::ST_TOO_LONG;
    else if (total_q >= TW'(TABLE_ENTRIES)) status = pkw_pkg::ST_FULL;
    else if (chain[TABLE_ENTRIES].dup) status = pkw_pkg::ST_DUPLICATE;
    else status = pkw_pkg::ST_OK;
  end

  always_comb begin
    ctrl     = '0;
    win_d    = win_q;
    fill_d   = fill_q;
    total_d  = total_q;
    result   = 1'b0;
    okind_d  = okind_q;
    oblk_d   = oblk_q;
    oidx_d   = oidx_q;
    ost_d    = ost_q;
    if (accept) begin
      case (cmd)
        pkw_pkg::CMD_PACKET: begin
          ctrl.match_en = searched;
          win_d  = win_n;
          fill_d = is_last ? '0 : fill_n;
          if (is_last) begin
            ctrl.clear_hits = 1'b1;
            result  = 1'b1;
            okind_d = pkw_pkg::KIND_VERDICT;
            oblk_d  = chain[TABLE_ENTRIES].found;
            oidx_d  = chain[TABLE_ENTRIES].found ? chain[TABLE_ENTRIES].index : 4'd0;
            ost_d   = pkw_pkg::ST_OK;
          end
        end
        pkw_pkg::CMD_KEYWORD: begin
          if (is_last) begin
            result  = 1'b1;
            okind_d = pkw_pkg::KIND_ADD;
            oblk_d  = 1'b0;
            oidx_d  = 4'd0;
            ost_d   = status;
            if (status == pkw_pkg::ST_OK) begin
              ctrl.write_en = 1'b1;
              total_d = total_q + 1'b1;
            end
          end
        end
        pkw_pkg::CMD_CLEAR: begin
          ctrl.clear_hits = 1'b1;
          total_d = '0;
          result  = 1'b1;
          okind_d = pkw_pkg::KIND_TABLE;
          oblk_d  = 1'b0;
          oidx_d  = 4'd0;
          ost_d   = pkw_pkg::ST_OK;
        end
        pkw_pkg::CMD_RESTORE: begin
          ctrl.clear_hits   = 1'b1;
          ctrl.load_default = 1'b1;
          total_d = TW'(1);
          result  = 1'b1;
          okind_d = pkw_pkg::KIND_TABLE;
          oblk_d  = 1'b0;
          oidx_d  = 4'd0;
          ost_d   = pkw_pkg::ST_OK;
        end
        default: begin
          result = 1'b0;
        end
      endcase
    end
  end

  assign total_wide = 32'(total_d);
  assign ocnt_d     = result ? total_wide[4:0] : ocnt_q;
  assign ovalid_d   = result ? 1'b1 : (m_axis_tready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      slen_q   <= '0;
      ended_q  <= 1'b0;
      total_q  <= TW'(1);
      ovalid_q <= 1'b0;
    end else begin
      win_q    <= win_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
      if (accept && (cmd == pkw_pkg::CMD_KEYWORD)) begin
        slen_q  <= is_last ? '0 : slen_d;
        ended_q <= is_last ? 1'b0 : ended_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd == pkw_pkg::CMD_KEYWORD)) begin
      stage_q <= stage_d;
    end
    okind_q <= okind_d;
    oblk_q  <= oblk_d;
    oidx_q  <= oidx_d;
    ost_q   <= ost_d;
    ocnt_q  <= ocnt_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = {3'b000, ocnt_q, ost_q, oidx_q, oblk_q};

endmodule
`default_nettype wire
